// ===== rtl/ssa_pkg.sv =====
`default_nettype none

package ssa_pkg;

	localparam int ID_W     = 64;
	localparam int TIME_W   = 48;
	localparam int SLOT_W   = 6;
	localparam int STATUS_W = 3;
	localparam int KIND_W   = 2;

	localparam logic [TIME_W-1:0] IDLE_LIMIT_RESET = TIME_W'(1000000);

	// request kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_START = 2'd0,
		KIND_CONT  = 2'd1,
		KIND_FREE  = 2'd2,
		KIND_REAP  = 2'd3
	} kind_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NO_FREE   = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_DUP       = 3'd3,
		ST_RELEASED  = 3'd4,
		ST_NONE_IDLE = 3'd5
	} status_t;

	// controller states
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN_RD,
		S_SCAN_CHK,
		S_FLUSH
	} fsm_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic exec;
		logic scan_rd;
		logic scan_chk;
		logic flush;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t in_kind;
		logic  out_free;
		logic  idle_hit;
		logic  pend_valid;
		logic  scan_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== rtl/ssa_ifs.sv =====
`default_nettype none

// request channel
interface ssa_req_if;
	logic                      valid;
	logic                      ready;
	logic [ssa_pkg::KIND_W-1:0] kind;
	logic [ssa_pkg::ID_W-1:0]   seq_id;
	logic [ssa_pkg::TIME_W-1:0] now_us;

	modport source (output valid, output kind, output seq_id, output now_us, input ready);
	modport sink (input valid, input kind, input seq_id, input now_us, output ready);
endinterface

// result channel
interface ssa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [ssa_pkg::STATUS_W-1:0] status;
	logic [ssa_pkg::SLOT_W-1:0]   slot;
	logic [ssa_pkg::ID_W-1:0]     out_seq_id;
	logic                        last;

	modport source (output valid, output status, output slot, output out_seq_id, output last,
		input ready);
	modport sink (input valid, input status, input slot, input out_seq_id, input last,
		output ready);
endinterface

// idle limit write channel
interface ssa_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [ssa_pkg::TIME_W-1:0] idle_limit_us;

	modport source (output valid, output idle_limit_us, input ready);
	modport sink (input valid, input idle_limit_us, output ready);
endinterface

`default_nettype wire

// ===== rtl/ssa_ram.sv =====
`default_nettype none

module ssa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, hold when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/ssa_ctrl.sv =====
`default_nettype none

module ssa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ssa_pkg::sts_t sts,
	output ssa_pkg::cmd_t      cmd
);

	ssa_pkg::fsm_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ssa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = (sts.in_kind == ssa_pkg::KIND_REAP) ? ssa_pkg::S_SCAN_RD
						: ssa_pkg::S_EXEC;
				end
			end
			ssa_pkg::S_EXEC: begin
				if (sts.out_free) begin
					cmd.exec = 1'b1;
					state_d  = ssa_pkg::S_IDLE;
				end
			end
			ssa_pkg::S_SCAN_RD: begin
				cmd.scan_rd = 1'b1;
				state_d     = ssa_pkg::S_SCAN_CHK;
			end
			ssa_pkg::S_SCAN_CHK: begin
				// hold while a pending release cannot be handed to the output
				if (!(sts.idle_hit && sts.pend_valid && !sts.out_free)) begin
					cmd.scan_chk = 1'b1;
					state_d = sts.scan_last ? ssa_pkg::S_FLUSH : ssa_pkg::S_SCAN_RD;
				end
			end
			ssa_pkg::S_FLUSH: begin
				if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ssa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ssa_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/ssa_dp.sv =====
`default_nettype none

module ssa_dp #(
	parameter int MAX_SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ssa_pkg::cmd_t                 cmd,
	output ssa_pkg::sts_t                      sts,
	input  wire logic [ssa_pkg::KIND_W-1:0]    in_kind,
	input  wire logic [ssa_pkg::ID_W-1:0]      in_seq_id,
	input  wire logic [ssa_pkg::TIME_W-1:0]    in_now_us,
	input  wire logic                          cfg_valid,
	input  wire logic [ssa_pkg::TIME_W-1:0]    cfg_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [ssa_pkg::STATUS_W-1:0]  out_status,
	output logic      [ssa_pkg::SLOT_W-1:0]    out_slot,
	output logic      [ssa_pkg::ID_W-1:0]      out_seq_id,
	output logic                               out_last
);

	localparam int SW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int CW   = $clog2(MAX_SLOTS + 1);
	localparam int SUMW = CW + 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_SLOTS);

	// control state
	logic [MAX_SLOTS-1:0]   bound_q;
	logic [MAX_SLOTS-1:0]   fifo_wr_q;
	logic [SW-1:0]          fifo_head_q;
	logic [CW-1:0]          fifo_count_q;
	logic [ssa_pkg::TIME_W-1:0] limit_q;
	logic [SW-1:0]          idx_q;
	logic                   pend_valid_q;
	logic                   out_valid_q;
	ssa_pkg::kind_t         kind_q;

	// payload state
	logic [ssa_pkg::ID_W-1:0]   cam_id_q [MAX_SLOTS];
	logic [ssa_pkg::ID_W-1:0]   id_q;
	logic [ssa_pkg::TIME_W-1:0] now_q;
	logic                       hit_q;
	logic [SW-1:0]              hit_idx_q;
	logic [SW-1:0]              pend_slot_q;
	logic [ssa_pkg::ID_W-1:0]   pend_id_q;
	ssa_pkg::status_t           out_status_q;
	logic [ssa_pkg::SLOT_W-1:0] out_slot_q;
	logic [ssa_pkg::ID_W-1:0]   out_id_q;
	logic                       out_last_q;

	// RAM read data
	logic [ssa_pkg::TIME_W-1:0] stamp_rd;
	logic [ssa_pkg::ID_W-1:0]   id_rd;
	logic [SW-1:0]              fifo_rd;

	logic [MAX_SLOTS-1:0]   match;
	logic                   match_any;
	logic [SW-1:0]          match_idx;
	logic [SW-1:0]          pop_slot;
	logic [SUMW-1:0]        tail_sum;
	logic [SW-1:0]          fifo_tail;
	logic [ssa_pkg::TIME_W-1:0] idle_time;
	logic                   idle_hit;
	logic                   start_ok;
	logic                   cont_ok;
	logic                   free_ok;
	logic                   pop;
	logic                   push_free;
	logic                   push_reap;
	logic                   push_en;
	logic [SW-1:0]          push_slot;
	logic                   out_free;
	logic                   out_load;
	ssa_pkg::status_t       exec_status;
	logic [SW-1:0]          exec_slot;
	logic                   stamp_we;
	logic [SW-1:0]          stamp_waddr;

	// associative match of the incoming id, lowest slot wins
	always_comb begin
		match_idx = '0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			match[i] = bound_q[i] && (cam_id_q[i] == in_seq_id);
		end
		for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin
				match_idx = SW'(i);
			end
		end
	end
	assign match_any = |match;

	// free list pointers; an entry never written holds its own index
	assign pop_slot  = fifo_wr_q[fifo_head_q] ? fifo_rd : fifo_head_q;
	assign tail_sum  = SUMW'(fifo_head_q) + SUMW'(fifo_count_q);
	assign fifo_tail = (tail_sum >= SUMW'(MAX_SLOTS)) ? SW'(tail_sum - SUMW'(MAX_SLOTS))
		: SW'(tail_sum);

	// idle test for the slot under scan
	assign idle_time = now_q - stamp_rd;
	assign idle_hit  = bound_q[idx_q] && (idle_time > limit_q);

	// decode the executed request
	assign start_ok  = (kind_q == ssa_pkg::KIND_START) && !hit_q && (fifo_count_q != '0);
	assign cont_ok   = (kind_q == ssa_pkg::KIND_CONT) && hit_q;
	assign free_ok   = (kind_q == ssa_pkg::KIND_FREE) && hit_q;
	assign pop       = cmd.exec && start_ok;
	assign push_free = cmd.exec && free_ok;
	assign push_reap = cmd.scan_chk && idle_hit;
	assign push_slot = push_free ? hit_idx_q : idx_q;
	assign push_en   = (push_free || push_reap) && (fifo_count_q != FULL_CNT);

	always_comb begin
		exec_status = ssa_pkg::ST_OK;
		exec_slot   = '0;
		case (kind_q) inside
			ssa_pkg::KIND_START: begin
				if (hit_q) begin
					exec_status = ssa_pkg::ST_DUP;
				end else if (fifo_count_q == '0) begin
					exec_status = ssa_pkg::ST_NO_FREE;
				end else begin
					exec_slot = pop_slot;
				end
			end
			ssa_pkg::KIND_CONT, ssa_pkg::KIND_FREE: begin
				if (hit_q) begin
					exec_slot = hit_idx_q;
				end else begin
					exec_status = ssa_pkg::ST_UNKNOWN;
				end
			end
			default: begin
				exec_status = ssa_pkg::ST_OK;
			end
		endcase
	end

	// stamp on start and continue
	assign stamp_we    = cmd.exec && (start_ok || cont_ok);
	assign stamp_waddr = start_ok ? pop_slot : hit_idx_q;

	ssa_ram #(
		.WIDTH(ssa_pkg::TIME_W),
		.DEPTH(MAX_SLOTS)
	) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (stamp_waddr),
		.wdata (now_q),
		.re    (cmd.scan_rd),
		.raddr (idx_q),
		.rdata (stamp_rd)
	);

	ssa_ram #(
		.WIDTH(ssa_pkg::ID_W),
		.DEPTH(MAX_SLOTS)
	) u_id_ram (
		.clk   (clk),
		.we    (pop),
		.waddr (pop_slot),
		.wdata (id_q),
		.re    (cmd.scan_rd),
		.raddr (idx_q),
		.rdata (id_rd)
	);

	ssa_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_SLOTS)
	) u_fifo_ram (
		.clk   (clk),
		.we    (push_en),
		.waddr (fifo_tail),
		.wdata (push_slot),
		.re    (cmd.capture),
		.raddr (fifo_head_q),
		.rdata (fifo_rd)
	);

	// output register
	assign out_free = !out_valid_q || out_ready;
	assign out_load = cmd.exec || cmd.flush || (cmd.scan_chk && idle_hit && pend_valid_q);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bound_q      <= '0;
			fifo_wr_q    <= '0;
			fifo_head_q  <= '0;
			fifo_count_q <= FULL_CNT;
			limit_q      <= ssa_pkg::IDLE_LIMIT_RESET;
			idx_q        <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= ssa_pkg::KIND_START;
		end else begin
			if (cfg_valid) begin
				limit_q <= cfg_data;
			end
			if (cmd.capture) begin
				kind_q       <= ssa_pkg::kind_t'(in_kind);
				idx_q        <= '0;
				pend_valid_q <= 1'b0;
			end
			// advance the scan, keep the newest release pending
			if (cmd.scan_chk) begin
				if (idx_q != LAST_SLOT) begin
					idx_q <= idx_q + SW'(1);
				end
				if (idle_hit) begin
					pend_valid_q <= 1'b1;
				end
			end
			if (pop) begin
				bound_q[pop_slot] <= 1'b1;
				fifo_head_q  <= (fifo_head_q == LAST_SLOT) ? '0 : fifo_head_q + SW'(1);
				fifo_count_q <= fifo_count_q - CW'(1);
			end
			if (push_free || push_reap) begin
				bound_q[push_slot] <= 1'b0;
			end
			if (push_en) begin
				fifo_wr_q[fifo_tail] <= 1'b1;
				fifo_count_q <= fifo_count_q + CW'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q      <= in_seq_id;
			now_q     <= in_now_us;
			hit_q     <= match_any;
			hit_idx_q <= match_idx;
		end
		if (pop) begin
			cam_id_q[pop_slot] <= id_q;
		end
		if (push_reap) begin
			pend_slot_q <= idx_q;
			pend_id_q   <= id_rd;
		end
		if (cmd.exec) begin
			out_status_q <= exec_status;
			out_slot_q   <= ssa_pkg::SLOT_W'(exec_slot);
			out_id_q     <= id_q;
			out_last_q   <= 1'b1;
		end else if (cmd.flush) begin
			out_last_q <= 1'b1;
			if (pend_valid_q) begin
				out_status_q <= ssa_pkg::ST_RELEASED;
				out_slot_q   <= ssa_pkg::SLOT_W'(pend_slot_q);
				out_id_q     <= pend_id_q;
			end else begin
				out_status_q <= ssa_pkg::ST_NONE_IDLE;
				out_slot_q   <= '0;
				out_id_q     <= '0;
			end
		end else if (out_load) begin
			out_status_q <= ssa_pkg::ST_RELEASED;
			out_slot_q   <= ssa_pkg::SLOT_W'(pend_slot_q);
			out_id_q     <= pend_id_q;
			out_last_q   <= 1'b0;
		end
	end

	assign sts.in_kind    = ssa_pkg::kind_t'(in_kind);
	assign sts.out_free   = out_free;
	assign sts.idle_hit   = idle_hit;
	assign sts.pend_valid = pend_valid_q;
	assign sts.scan_last  = (idx_q == LAST_SLOT);

	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_slot   = out_slot_q;
	assign out_seq_id = out_id_q;
	assign out_last   = out_last_q;

	// every slot is either bound or waiting in the free list
	assert property (@(posedge clk) disable iff (!arst_n)
		$countones(bound_q) + int'(fifo_count_q) == MAX_SLOTS)
		else $error("slot accounting broken");

	// never overwrite a result that has not been taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");

	// a granted slot is never already bound
	assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !bound_q[pop_slot])
		else $error("granted slot already bound");

	// a release always comes from a bound slot and finds room in the free list
	assert property (@(posedge clk) disable iff (!arst_n)
		(push_free || push_reap) |-> (bound_q[push_slot] && fifo_count_q != FULL_CNT))
		else $error("release of unbound slot or full free list");

endmodule

`default_nettype wire

// ===== rtl/sequence_slot_allocator_unit.sv =====
// Binds 64-bit sequence ids to MAX_SLOTS slots taken from a free list and
// releases slots that sat idle longer than idle_limit_us. A start, continue or
// free request matches its id against all bound slots in the accept cycle and
// updates the slot tables once the output is free. A reap request walks the
// slots one at a time through the stamp memory read port, each read in a read
// state and tested in a check state, then a flush state; both wait on a
// stalled result channel. One beat leaves per released slot, or a single "none
// idle" beat, with last on the final one. Results sit in an output register,
// so a new request is taken while the previous result waits. Reset needs no
// clearing pass. Write idle_limit_us only while no request is in flight.
`default_nettype none

module sequence_slot_allocator_unit #(
	parameter int MAX_SLOTS = 16
) (
	input wire logic   clk,
	input wire logic   arst_n,
	ssa_req_if.sink    req,
	ssa_rsp_if.source  rsp,
	ssa_cfg_if.sink    cfg
);

	ssa_pkg::cmd_t cmd;
	ssa_pkg::sts_t sts;

	// idle limit writes are always taken
	assign cfg.ready = 1'b1;

	ssa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ssa_dp #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_kind    (req.kind),
		.in_seq_id  (req.seq_id),
		.in_now_us  (req.now_us),
		.cfg_valid  (cfg.valid),
		.cfg_data   (cfg.idle_limit_us),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.out_status (rsp.status),
		.out_slot   (rsp.slot),
		.out_seq_id (rsp.out_seq_id),
		.out_last   (rsp.last)
	);

endmodule

`default_nettype wire
